>>> rtl/rpcp_pkg.sv
package rpcp_pkg;

  localparam int unsigned CoordBits = 12;
  localparam logic [11:0] CoordMask = 12'((64'd1 << CoordBits) - 64'd1);

  localparam logic [23:0] WRed   = 24'd19595;
  localparam logic [23:0] WGreen = 24'd38470;
  localparam logic [23:0] WBlue  = 24'd7471;

  // floor(s / 3) == (s * 174763) >> 19 for every s below 2^19
  localparam logic [35:0] Div3Mul   = 36'd174763;
  localparam int unsigned Div3Shift = 19;

  localparam logic signed [25:0] KChromaU     = 26'sd36962;
  localparam logic signed [25:0] KChromaV     = 26'sd46727;
  localparam logic signed [25:0] ChromaOffset = 26'sd8388608;

  localparam logic [9:0] ClampLo = 10'd16;
  localparam logic [9:0] ClampHi = 10'd235;

  localparam int unsigned IsqrtStages = 4;

  typedef enum logic {
    REG_IMAGE_WIDTH = 1'b0,
    REG_BORDER_SIZE = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [7:0] yellow;
    logic [7:0] luma;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
    logic       in_core;
  } side_t;

  typedef struct packed {
    logic [16:0] rem;
    logic [7:0]  root;
  } sq_t;

  function automatic logic [7:0] clamp_studio(input logic [9:0] v);
    logic [7:0] res;
    if (v < ClampLo) begin
      res = ClampLo[7:0];
    end else if (v > ClampHi) begin
      res = ClampHi[7:0];
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  function automatic logic [7:0] clamp_chroma(input logic signed [25:0] t);
    logic [7:0] res;
    if (t < 0) begin
      res = ClampLo[7:0];
    end else begin
      res = clamp_studio(t[25:16]);
    end
    return res;
  endfunction

  // one digit of the restoring square root: try bit pos of the root
  function automatic sq_t sq_step(input logic [16:0] rem, input logic [7:0] root,
                                  input int unsigned pos);
    logic [16:0] trial;
    sq_t         res;
    trial = (17'(root) << (pos + 1)) + (17'd1 << (2 * pos));
    if (rem >= trial) begin
      res.rem  = rem - trial;
      res.root = root | (8'd1 << pos);
    end else begin
      res.rem  = rem;
      res.root = root;
    end
    return res;
  endfunction

endpackage

>>> rtl/rgb_pixel_color_planes.sv
// RGB pixel color planes.
// Input channel (in_valid / in_stall): one RGB pixel with its column and row
// in the border-extended image per transfer.
// Output channel (out_valid / out_stall): one result per pixel, in order:
// yellow, intensity (isqrt of mean square), clamped luma, clamped chroma U/V
// and the core-region flag.
// Configuration: cfg_we writes cfg_data into image_width (index 0) or
// border_size (index 1); write only while no pixel is in flight.
// The pipeline has five arithmetic stages (products, sums, divide by
// three, chroma products, clamps) followed by four square root stages that
// each resolve two root bits.
// Throughput is one pixel per cycle while out_stall is low; each stage moves when the stage ahead
// is empty or moving.
// Reset (synchronous, rst_n low) empties the pipeline and loads
// image_width = 256, border_size = 7.
// While out_stall is high the result holds; stages behind it keep filling
// bubbles and in_stall rises once every stage holds a pixel.
module rgb_pixel_color_planes (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  rpcp_pkg::reg_index_t     cfg_index,
  input  logic [12:0]              cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_red,
  input  logic [7:0]               in_green,
  input  logic [7:0]               in_blue,
  input  logic [11:0]              in_column,
  input  logic [11:0]              in_row,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [7:0]               out_yellow,
  output logic [7:0]               out_intensity,
  output logic [7:0]               out_luma,
  output logic [7:0]               out_chroma_u,
  output logic [7:0]               out_chroma_v,
  output logic                     out_in_core
);
  import rpcp_pkg::*;

  logic [12:0] image_width_r;
  logic [5:0]  border_size_r;

  logic        mid_valid, mid_stall;
  logic [15:0] mid_quot;
  side_t       mid_side;
  side_t       res_side;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= 13'd256;
      border_size_r <= 6'd7;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: image_width_r <= cfg_data;
        REG_BORDER_SIZE: border_size_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  rpcp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .in_column  (in_column),
    .in_row     (in_row),
    .image_width(image_width_r),
    .border_size(border_size_r),
    .out_valid  (mid_valid),
    .out_stall  (mid_stall),
    .out_quot   (mid_quot),
    .out_side   (mid_side)
  );

  rpcp_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (mid_valid),
    .in_stall (mid_stall),
    .in_quot  (mid_quot),
    .in_side  (mid_side),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_root (out_intensity),
    .out_side (res_side)
  );

  assign out_yellow   = res_side.yellow;
  assign out_luma     = res_side.luma;
  assign out_chroma_u = res_side.chroma_u;
  assign out_chroma_v = res_side.chroma_v;
  assign out_in_core  = res_side.in_core;

endmodule

>>> rtl/rpcp_front.sv
module rpcp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_red,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_blue,
  input  logic [11:0]        in_column,
  input  logic [11:0]        in_row,
  input  logic [12:0]        image_width,
  input  logic [5:0]         border_size,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_quot,
  output rpcp_pkg::side_t    out_side
);
  import rpcp_pkg::*;

  logic va_r, vb_r, vc_r, vd_r, ve_r;
  logic sa, sb, sc, sd, se;

  // stage A: products
  logic [7:0]  r_a_r, b_a_r, yel_a_r;
  logic [15:0] sqr_a_r, sqg_a_r, sqb_a_r;
  logic [23:0] lr_a_r, lg_a_r, lb_a_r;
  logic        core_a_r;
  // stage B: sums, luma
  logic [7:0]  r_b_r, b_b_r, yel_b_r, luma_b_r;
  logic [17:0] sumsq_b_r;
  logic        core_b_r;
  // stage C: divide-by-three product, chroma differences
  logic [35:0]       prod3_c_r;
  logic signed [8:0] du_c_r, dv_c_r;
  logic [7:0]        yel_c_r, luma_c_r;
  logic              core_c_r;
  // stage D: quotient, chroma products
  logic [15:0]        quot_d_r;
  logic signed [25:0] tu_d_r, tv_d_r;
  logic [7:0]         yel_d_r, luma_d_r;
  logic               core_d_r;
  // stage E: clamped chroma
  logic [15:0] quot_e_r;
  side_t       side_e_r;

  logic [11:0] col, row;
  logic        core_nxt;
  logic [23:0] ysum;

  assign se = ve_r & out_stall;
  assign sd = vd_r & se;
  assign sc = vc_r & sd;
  assign sb = vb_r & sc;
  assign sa = va_r & sb;
  assign in_stall = sa;

  assign col = in_column & CoordMask;
  assign row = in_row & CoordMask;
  assign core_nxt = (row >= 12'(border_size)) && (col >= 12'(border_size)) &&
                    ((14'(col) + 14'(border_size)) < 14'(image_width));

  assign ysum = lr_a_r + lg_a_r + lb_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else begin
      if (!sa) va_r <= in_valid;
      if (!sb) vb_r <= va_r;
      if (!sc) vc_r <= vb_r;
      if (!sd) vd_r <= vc_r;
      if (!se) ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!sa) begin
      r_a_r    <= in_red;
      b_a_r    <= in_blue;
      yel_a_r  <= {1'b0, in_red[7:1]} + {1'b0, in_green[7:1]};
      sqr_a_r  <= 16'(in_red) * 16'(in_red);
      sqg_a_r  <= 16'(in_green) * 16'(in_green);
      sqb_a_r  <= 16'(in_blue) * 16'(in_blue);
      lr_a_r   <= 24'(in_red) * WRed;
      lg_a_r   <= 24'(in_green) * WGreen;
      lb_a_r   <= 24'(in_blue) * WBlue;
      core_a_r <= core_nxt;
    end
    if (!sb) begin
      r_b_r     <= r_a_r;
      b_b_r     <= b_a_r;
      yel_b_r   <= yel_a_r;
      sumsq_b_r <= 18'(sqr_a_r) + 18'(sqg_a_r) + 18'(sqb_a_r);
      luma_b_r  <= clamp_studio({2'b00, ysum[23:16]});
      core_b_r  <= core_a_r;
    end
    if (!sc) begin
      prod3_c_r <= 36'(sumsq_b_r) * Div3Mul;
      du_c_r    <= $signed({1'b0, b_b_r}) - $signed({1'b0, luma_b_r});
      dv_c_r    <= $signed({1'b0, r_b_r}) - $signed({1'b0, luma_b_r});
      yel_c_r   <= yel_b_r;
      luma_c_r  <= luma_b_r;
      core_c_r  <= core_b_r;
    end
    if (!sd) begin
      quot_d_r <= prod3_c_r[Div3Shift +: 16];
      tu_d_r   <= 26'(du_c_r) * KChromaU + ChromaOffset;
      tv_d_r   <= 26'(dv_c_r) * KChromaV + ChromaOffset;
      yel_d_r  <= yel_c_r;
      luma_d_r <= luma_c_r;
      core_d_r <= core_c_r;
    end
    if (!se) begin
      quot_e_r          <= quot_d_r;
      side_e_r.yellow   <= yel_d_r;
      side_e_r.luma     <= luma_d_r;
      side_e_r.chroma_u <= clamp_chroma(tu_d_r);
      side_e_r.chroma_v <= clamp_chroma(tv_d_r);
      side_e_r.in_core  <= core_d_r;
    end
  end

  assign out_valid = ve_r;
  assign out_quot  = quot_e_r;
  assign out_side  = side_e_r;

endmodule

>>> rtl/rpcp_isqrt.sv
module rpcp_isqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [15:0]     in_quot,
  input  rpcp_pkg::side_t in_side,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_root,
  output rpcp_pkg::side_t out_side
);
  import rpcp_pkg::*;

  // two root bits per stage, most significant first
  logic        v_r    [IsqrtStages];
  logic [16:0] rem_r  [IsqrtStages];
  logic [7:0]  root_r [IsqrtStages];
  side_t       side_r [IsqrtStages];

  logic        src_v    [IsqrtStages];
  logic [16:0] src_rem  [IsqrtStages];
  logic [7:0]  src_root [IsqrtStages];
  side_t       src_side [IsqrtStages];
  sq_t         mid      [IsqrtStages];
  sq_t         fin      [IsqrtStages];
  logic        st       [IsqrtStages];

  always_comb begin
    src_v[0]    = in_valid;
    src_rem[0]  = {1'b0, in_quot};
    src_root[0] = '0;
    src_side[0] = in_side;
    for (int s = 1; s < IsqrtStages; s++) begin
      src_v[s]    = v_r[s-1];
      src_rem[s]  = rem_r[s-1];
      src_root[s] = root_r[s-1];
      src_side[s] = side_r[s-1];
    end
    for (int s = 0; s < IsqrtStages; s++) begin
      mid[s] = sq_step(src_rem[s], src_root[s], 32'(7 - 2 * s));
      fin[s] = sq_step(mid[s].rem, mid[s].root, 32'(6 - 2 * s));
    end
    st[IsqrtStages-1] = v_r[IsqrtStages-1] & out_stall;
    for (int s = IsqrtStages - 2; s >= 0; s--) begin
      st[s] = v_r[s] & st[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < IsqrtStages; s++) v_r[s] <= 1'b0;
    end else begin
      for (int s = 0; s < IsqrtStages; s++) begin
        if (!st[s]) v_r[s] <= src_v[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < IsqrtStages; s++) begin
      if (!st[s]) begin
        rem_r[s]  <= fin[s].rem;
        root_r[s] <= fin[s].root;
        side_r[s] <= src_side[s];
      end
    end
  end

  assign in_stall  = st[0];
  assign out_valid = v_r[IsqrtStages-1];
  assign out_root  = root_r[IsqrtStages-1];
  assign out_side  = side_r[IsqrtStages-1];

endmodule
